/* design/happ_pkg.sv */
package happ_pkg;

    localparam int STORED_CHARS = 20;
    localparam int CFG_ADDR_W = 3;
    localparam int OUT_TDATA_W = 88;
    localparam int OUT_TUSER_W = 2;

    localparam logic [7:0] DIR_CODE_RESET = 8'd5;

    // Register select bit of paddr (word index).
    localparam logic REG_DIR_CODE = 1'b0;

    localparam logic FUNC_CHAR = 1'b0;
    localparam logic FUNC_TIMEOUT = 1'b1;

    localparam logic END_TIMEOUT = 1'b0;
    localparam logic END_FULL = 1'b1;

    typedef logic [STORED_CHARS-1:0][3:0] nibble_arr_t;

    typedef struct packed {
        logic done;
        logic cause;
    } frame_evt_t;

    typedef struct packed {
        logic [7:0]  revision;
        logic [7:0]  packet_type;
        logic [7:0]  packet_length;
        logic [15:0] heading;
        logic [15:0] x_coord;
        logic [15:0] y_coord;
        logic [7:0]  check_byte;
        logic        is_direction;
        logic        sum_ok;
        logic        pose_ready;
    } fields_t;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                d = c - 8'h30;
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                d = c - 8'h37;
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                d = c - 8'h57;
            end
            return d[3:0];
        end
    endfunction

endpackage

/* design/hex_ascii_pose_packet_parser.sv */
// Hex-ASCII pose packet parser.
// The slave stream carries one item per received character (tuser = 0, the
// character in tdata[7:0]) or a receive timeout event (tuser = 1). Characters
// fill a frame of two halves of HALF_BUFFER_CHARS each; a frame ends on a
// timeout once the current half holds at least one character, or when the
// second half fills. The first twenty characters are decoded into the packet
// fields, and one item is sent on the master stream for each completed frame.
// The APB port holds the direction type code at address 0 (reset value 5).
// An accepted item is registered, then processed by the framer and field
// decoder when it advances, and a frame's result is written into the output
// register. One item is accepted every cycle while the output is not stalled.
// When the receiver stalls, the output register holds its item; the input
// register then fills and s_tready drops until the output item is taken.
// Reset clears the frame, the sticky ready flag and both stream valid flags.
module hex_ascii_pose_packet_parser #(
    parameter int HALF_BUFFER_CHARS = 512
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,  // rx_char
    input  logic [0:0]                           s_tuser,  // func
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // revision, packet_type, packet_length, heading, x_coord, y_coord,
    // check_byte, sum_ok, pose_ready, zero fill
    output logic [happ_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [happ_pkg::OUT_TUSER_W-1:0]     m_tuser,  // is_direction, end_cause
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [happ_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    logic                  in_valid_reg;
    logic                  in_func_reg;
    logic [7:0]            in_char_reg;
    logic                  out_valid_reg;
    happ_pkg::fields_t     out_fields_reg;
    logic                  out_cause_reg;
    logic                  advance;
    logic [7:0]            dir_code;
    happ_pkg::nibble_arr_t nibbles;
    happ_pkg::frame_evt_t  evt;
    happ_pkg::fields_t     fields;

    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    happ_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .dir_code (dir_code)
    );

    happ_framer #(
        .HALF_BUFFER_CHARS (HALF_BUFFER_CHARS)
    ) u_framer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .func    (in_func_reg),
        .rx_char (in_char_reg),
        .nibbles (nibbles),
        .evt     (evt)
    );

    happ_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .nibbles  (nibbles),
        .dir_code (dir_code),
        .finish   (advance && evt.done),
        .fields   (fields)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_func_reg <= s_tuser[0];
            in_char_reg <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && evt.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && evt.done)
        begin
            out_fields_reg <= fields;
            out_cause_reg <= evt.cause;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {6'h00,
                      out_fields_reg.pose_ready,
                      out_fields_reg.sum_ok,
                      out_fields_reg.check_byte,
                      out_fields_reg.y_coord,
                      out_fields_reg.x_coord,
                      out_fields_reg.heading,
                      out_fields_reg.packet_length,
                      out_fields_reg.packet_type,
                      out_fields_reg.revision};
    assign m_tuser = {out_cause_reg, out_fields_reg.is_direction};

endmodule

/* design/happ_cfg.sv */
module happ_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [happ_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [7:0]                      dir_code
);

    logic [7:0] dir_code_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite && (paddr[2] == happ_pkg::REG_DIR_CODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_code_reg <= happ_pkg::DIR_CODE_RESET;
        end
        else if (wr_en)
        begin
            dir_code_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = 32'h0;
        if (paddr[2] == happ_pkg::REG_DIR_CODE)
        begin
            prdata = {24'h0, dir_code_reg};
        end
    end

    assign dir_code = dir_code_reg;

endmodule

/* design/happ_framer.sv */
module happ_framer #(
    parameter int HALF_BUFFER_CHARS = 512
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  func,
    input  logic [7:0]            rx_char,
    output happ_pkg::nibble_arr_t nibbles,
    output happ_pkg::frame_evt_t  evt
);

    localparam int CW = $clog2(HALF_BUFFER_CHARS);
    localparam logic [CW-1:0] LAST_POS = CW'(HALF_BUFFER_CHARS - 1);
    localparam logic [CW-1:0] STORE_LIMIT = CW'(happ_pkg::STORED_CHARS);

    happ_pkg::nibble_arr_t nib_reg, nib_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic                  upper_reg, upper_next;

    always_comb
    begin
        nib_next = nib_reg;
        pos_next = pos_reg;
        upper_next = upper_reg;
        evt.done = 1'b0;
        evt.cause = happ_pkg::END_TIMEOUT;
        if (func == happ_pkg::FUNC_TIMEOUT)
        begin
            if (pos_reg != '0)
            begin
                evt.done = 1'b1;
                evt.cause = happ_pkg::END_TIMEOUT;
            end
            if (pos_reg != '0 || upper_reg)
            begin
                nib_next = '0;
                pos_next = '0;
                upper_next = 1'b0;
            end
        end
        else
        begin
            if (!upper_reg && pos_reg < STORE_LIMIT)
            begin
                nib_next[pos_reg[4:0]] = happ_pkg::hex_nibble(rx_char);
            end
            if (pos_reg == LAST_POS)
            begin
                pos_next = '0;
                if (!upper_reg)
                begin
                    upper_next = 1'b1;
                end
                else
                begin
                    evt.done = 1'b1;
                    evt.cause = happ_pkg::END_FULL;
                    nib_next = '0;
                    upper_next = 1'b0;
                end
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nib_reg <= '0;
            pos_reg <= '0;
            upper_reg <= 1'b0;
        end
        else if (step)
        begin
            nib_reg <= nib_next;
            pos_reg <= pos_next;
            upper_reg <= upper_next;
        end
    end

    assign nibbles = nib_reg;

endmodule

/* design/happ_decode.sv */
module happ_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  happ_pkg::nibble_arr_t nibbles,
    input  logic [7:0]            dir_code,
    input  logic                  finish,
    output happ_pkg::fields_t     fields
);

    logic       ready_reg;
    logic [7:0] rev, typ, len, chk, sum;
    logic       isdir, ok;
    logic [15:0] hd, xc, yc;

    assign rev = {nibbles[0], nibbles[1]};
    assign typ = {nibbles[2], nibbles[3]};
    assign len = {nibbles[4], nibbles[5]};
    assign chk = {nibbles[18], nibbles[19]};
    assign isdir = (typ == dir_code);

    assign hd = isdir ? {nibbles[6], nibbles[7], nibbles[8], nibbles[9]} : 16'h0;
    assign xc = isdir ? {nibbles[10], nibbles[11], nibbles[12], nibbles[13]} : 16'h0;
    assign yc = isdir ? {nibbles[14], nibbles[15], nibbles[16], nibbles[17]} : 16'h0;

    assign sum = rev + typ + len + hd[7:0] + xc[7:0] + yc[7:0] + chk;
    assign ok = isdir && (sum == 8'h00);

    // The ready flag is sticky and only direction packets rewrite it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
        end
        else if (finish && isdir)
        begin
            ready_reg <= ok;
        end
    end

    always_comb
    begin
        fields.revision = rev;
        fields.packet_type = typ;
        fields.packet_length = len;
        fields.heading = hd;
        fields.x_coord = xc;
        fields.y_coord = yc;
        fields.check_byte = chk;
        fields.is_direction = isdir;
        fields.sum_ok = ok;
        fields.pose_ready = isdir ? ok : ready_reg;
    end

endmodule
